// File: src/sti_pkg.sv
// ---------------------------------------------------------------------------
// sti_pkg: shared constants and table builder for the sine interpolator
// Field widths, saturation limits and the elaboration-time function that
// computes one quarter-wave sine sample in Q30 integer arithmetic.
// ---------------------------------------------------------------------------
package sti_pkg;

	// word field widths
	localparam int PHASE_W = 32;
	localparam int SINE_W  = 16;
	localparam int FRAC_W  = 24;

	// Q1.15 result limits
	localparam logic signed [SINE_W-1:0] SINE_MAX = 16'sh7FFF;
	localparam logic signed [SINE_W-1:0] SINE_MIN = 16'sh8000;

	// pi/2 in Q30 and the Taylor series setup
	localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
	localparam int          TAYLOR_TERMS = 10;
	// (2k)(2k+1) for k = 1..10
	localparam logic [8:0] TAYLOR_DIV [TAYLOR_TERMS] =
		'{9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342, 9'd420};

	// Magnitude of sample j of a quarter wave of 2^qlog steps:
	// round(sin(j * pi/2 / 2^qlog) * 32768), capped at 32767.
	// Only called with constant arguments, so it folds away at elaboration.
	function automatic logic [SINE_W-1:0] quarter_entry(input logic [11:0] j,
			input int unsigned qlog);
		logic [63:0]        ang;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic signed [63:0] v;
		ang  = (64'(j) * HALF_PI_Q30) >> qlog;
		term = ang;
		sum  = $signed(ang);
		for (int k = 0; k < TAYLOR_TERMS; k++) begin
			term = (term * ang) >> 30;
			term = (term * ang) >> 30;
			term = term / 64'(TAYLOR_DIV[k]);
			if ((k & 1) == 0) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = (sum + 64'sd16384) >>> 15;
		if (v > 64'sd32767) begin
			v = 64'sd32767;
		end
		return v[SINE_W-1:0];
	endfunction

endpackage

// File: src/sti_phase_if.sv
// ---------------------------------------------------------------------------
// sti_phase_if: phase input channel
// Valid/ready channel carrying one signed Q8.24 phase word in turns.
// ---------------------------------------------------------------------------
interface sti_phase_if import sti_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [PHASE_W-1:0] phase;

	modport source (output valid, output phase, input ready);
	modport sink (input valid, input phase, output ready);
endinterface

// File: src/sti_sine_if.sv
// ---------------------------------------------------------------------------
// sti_sine_if: sine result channel
// Valid/ready channel carrying one signed Q1.15 sine word.
// ---------------------------------------------------------------------------
interface sti_sine_if import sti_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [SINE_W-1:0] sine_value;

	modport source (output valid, output sine_value, input ready);
	modport sink (input valid, input sine_value, output ready);
endinterface

// File: src/sine_table_interpolator.sv
// ---------------------------------------------------------------------------
// sine_table_interpolator: sine of a phase in turns by table interpolation
// Usage:
//   phase_ch carries one signed Q8.24 phase word in turns; only the 24
//   fraction bits matter, negative phases wrap to the same fraction.
//   sine_ch returns one signed Q1.15 sine word for every phase word, in order.
//   The top index bits of the fraction pick two neighboring samples of a
//   TABLE_SIZE-step sine period, the remaining bits weight them linearly.
//   TABLE_SIZE is a power of two. The samples come from a quarter-wave
//   constant table built at elaboration, read twice per word.
// Pipeline: one register per stage (fold, table read, difference, multiply,
//   add/clamp) between an accepted phase word and its sine word.
// Throughput: one word per cycle while sine_ch is ready; the 17 x 16 bit signed
//   multiply (at the default table size) and the table read each own a stage.
// Reset: clears all stage valid bits; the block accepts words right after.
// Stall: when sine_ch is not ready, each stage holds its word and fills
//   bubbles ahead of it; phase_ch.ready drops only once all five stages hold
//   a word. No word is dropped or repeated.
// ---------------------------------------------------------------------------
module sine_table_interpolator import sti_pkg::*; #(
	parameter int TABLE_SIZE = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	sti_phase_if.sink   phase_ch,
	sti_sine_if.source  sine_ch
);
	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int R_W   = FRAC_W - IDX_W;

	logic                     v_s1;
	logic [IDX_W-1:0]         fa_s1;
	logic [IDX_W-1:0]         fb_s1;
	logic [R_W-1:0]           r_s1;
	logic                     fetch_ready;
	logic                     v_s3;
	logic signed [SINE_W-1:0] a_s3;
	logic signed [SINE_W:0]   diff_s3;
	logic [R_W-1:0]           r_s3;
	logic                     interp_ready;
	logic                     in_acc;
	logic                     flow_ok;

	// stage 1: index split and fold
	sti_addr_gen #(.TABLE_SIZE(TABLE_SIZE)) u_addr_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (phase_ch.valid),
		.phase     (phase_ch.phase),
		.in_ready  (phase_ch.ready),
		.v_s1      (v_s1),
		.fa_s1     (fa_s1),
		.fb_s1     (fb_s1),
		.r_s1      (r_s1),
		.out_ready (fetch_ready)
	);

	// stages 2-3: table read and difference
	sti_sample_fetch #(.TABLE_SIZE(TABLE_SIZE)) u_sample_fetch (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.fa        (fa_s1),
		.fb        (fb_s1),
		.r         (r_s1),
		.in_ready  (fetch_ready),
		.v_s3      (v_s3),
		.a_s3      (a_s3),
		.diff_s3   (diff_s3),
		.r_s3      (r_s3),
		.out_ready (interp_ready)
	);

	// stages 4-5: multiply, add, clamp
	sti_interp #(.TABLE_SIZE(TABLE_SIZE)) u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.a         (a_s3),
		.diff      (diff_s3),
		.r         (r_s3),
		.in_ready  (interp_ready),
		.v_s5      (sine_ch.valid),
		.y_s5      (sine_ch.sine_value),
		.out_ready (sine_ch.ready)
	);

	assign in_acc  = phase_ch.valid && phase_ch.ready && arst_n;
	assign flow_ok = sine_ch.ready && arst_n;

	// a ready receiver never backs up into the input
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		sine_ch.ready |-> phase_ch.ready)
		else $error("input stalled while output is ready");

	// with the receiver ready throughout, every accepted word comes out of the pipeline
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		($past(in_acc, 5) && $past(flow_ok, 4) && $past(flow_ok, 3) &&
		 $past(flow_ok, 2) && $past(flow_ok, 1)) |-> sine_ch.valid)
		else $error("word missing at pipeline exit");

endmodule

// File: src/sti_addr_gen.sv
// ---------------------------------------------------------------------------
// sti_addr_gen: phase split and quarter-wave address fold (stage 1)
// Splits the phase fraction into table index and interpolation weight and
// folds both neighbor indexes onto the quarter-wave table with a sign flag.
// ---------------------------------------------------------------------------
module sti_addr_gen import sti_pkg::*; #(
	parameter int TABLE_SIZE = 512
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic signed [PHASE_W-1:0] phase,
	output logic                     in_ready,
	output logic                     v_s1,
	output logic [$clog2(TABLE_SIZE)-1:0] fa_s1,
	output logic [$clog2(TABLE_SIZE)-1:0] fb_s1,
	output logic [FRAC_W-$clog2(TABLE_SIZE)-1:0] r_s1,
	input  logic                     out_ready
);
	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int I_W   = IDX_W + 1;
	localparam int J_W   = IDX_W - 1;
	localparam int R_W   = FRAC_W - IDX_W;
	localparam int QN    = TABLE_SIZE / 4;

	logic           en_s1;
	logic [I_W-1:0] ia;
	logic [I_W-1:0] ib;

	// fold a full-period index onto the quarter wave: {negate, quarter index}
	function automatic logic [J_W:0] fold(input logic [I_W-1:0] i);
		logic [I_W-1:0] m;
		logic           neg;
		if (i <= I_W'(QN)) begin
			m   = i;
			neg = 1'b0;
		end else if (i <= I_W'(2 * QN)) begin
			m   = I_W'(2 * QN) - i;
			neg = 1'b0;
		end else if (i <= I_W'(3 * QN)) begin
			m   = i - I_W'(2 * QN);
			neg = 1'b1;
		end else begin
			m   = I_W'(TABLE_SIZE) - i;
			neg = 1'b1;
		end
		return {neg, m[J_W-1:0]};
	endfunction

	// integer bits of the phase drop out; the fraction wraps by itself
	assign ia = {1'b0, phase[FRAC_W-1 -: IDX_W]};
	assign ib = ia + I_W'(1);

	assign en_s1    = !v_s1 || out_ready;
	assign in_ready = en_s1;

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			fa_s1 <= fold(ia);
			fb_s1 <= fold(ib);
			r_s1  <= phase[R_W-1:0];
		end
	end

endmodule

// File: src/sti_sample_fetch.sv
// ---------------------------------------------------------------------------
// sti_sample_fetch: quarter-wave table read and neighbor difference
// Stage 2 reads both neighbor samples and restores their sign, stage 3
// forms the difference used for the interpolation.
// ---------------------------------------------------------------------------
module sti_sample_fetch import sti_pkg::*; #(
	parameter int TABLE_SIZE = 512
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [$clog2(TABLE_SIZE)-1:0] fa,
	input  logic [$clog2(TABLE_SIZE)-1:0] fb,
	input  logic [FRAC_W-$clog2(TABLE_SIZE)-1:0] r,
	output logic                     in_ready,
	output logic                     v_s3,
	output logic signed [SINE_W-1:0] a_s3,
	output logic signed [SINE_W:0]   diff_s3,
	output logic [FRAC_W-$clog2(TABLE_SIZE)-1:0] r_s3,
	input  logic                     out_ready
);
	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int J_W   = IDX_W - 1;
	localparam int R_W   = FRAC_W - IDX_W;
	localparam int QN    = TABLE_SIZE / 4;
	// largest step between neighbors stays well below this at the default table size
	localparam logic signed [SINE_W:0] STEP_LIMIT = 17'sd4096;

	logic                     en_s2;
	logic                     en_s3;
	logic                     v_s2;
	logic signed [SINE_W-1:0] a_s2;
	logic signed [SINE_W-1:0] b_s2;
	logic [R_W-1:0]           r_s2;
	logic [SINE_W-1:0]        mag_a;
	logic [SINE_W-1:0]        mag_b;
	logic [SINE_W-1:0]        qtab [QN+1];

	// quarter-wave sample table, constant after elaboration
	for (genvar g = 0; g <= QN; g++) begin : g_qtab
		assign qtab[g] = quarter_entry(12'(g), IDX_W - 2);
	end

	assign mag_a = qtab[fa[J_W-1:0]];
	assign mag_b = qtab[fb[J_W-1:0]];

	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign in_ready = en_s2;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s2) begin
				v_s2 <= in_valid;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// stage 2: signed samples
	always_ff @(posedge clk) begin
		if (en_s2 && in_valid) begin
			a_s2 <= fa[J_W] ? -$signed(mag_a) : $signed(mag_a);
			b_s2 <= fb[J_W] ? -$signed(mag_b) : $signed(mag_b);
			r_s2 <= r;
		end
	end

	// stage 3: neighbor difference
	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			a_s3    <= a_s2;
			diff_s3 <= (SINE_W+1)'(b_s2) - (SINE_W+1)'(a_s2);
			r_s3    <= r_s2;
		end
	end

	// neighbors of one sampled sine never differ by much
	a_step_small: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (diff_s3 < STEP_LIMIT && diff_s3 > -STEP_LIMIT))
		else $error("sample step out of range");

endmodule

// File: src/sti_interp.sv
// ---------------------------------------------------------------------------
// sti_interp: linear interpolation and output register
// Stage 4 multiplies the neighbor difference by the weight, stage 5 adds
// the floored fraction to the lower sample and saturates to Q1.15.
// ---------------------------------------------------------------------------
module sti_interp import sti_pkg::*; #(
	parameter int TABLE_SIZE = 512
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic signed [SINE_W-1:0] a,
	input  logic signed [SINE_W:0]   diff,
	input  logic [FRAC_W-$clog2(TABLE_SIZE)-1:0] r,
	output logic                     in_ready,
	output logic                     v_s5,
	output logic signed [SINE_W-1:0] y_s5,
	input  logic                     out_ready
);
	localparam int IDX_W  = $clog2(TABLE_SIZE);
	localparam int R_W    = FRAC_W - IDX_W;
	localparam int PROD_W = SINE_W + 1 + R_W + 1;
	localparam int SUM_W  = SINE_W + 2;

	logic                     en_s4;
	logic                     en_s5;
	logic                     v_s4;
	logic signed [PROD_W-1:0] prod_s4;
	logic signed [SINE_W-1:0] a_s4;
	logic signed [SUM_W-1:0]  q_c;
	logic signed [SUM_W-1:0]  sum_c;
	logic signed [SINE_W-1:0] sat_c;

	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign in_ready = en_s4;

	// arithmetic shift floors toward minus infinity
	assign q_c   = SUM_W'(prod_s4 >>> R_W);
	assign sum_c = SUM_W'(a_s4) + q_c;

	// clamp to Q1.15
	always_comb begin
		if (sum_c > SUM_W'(SINE_MAX)) begin
			sat_c = SINE_MAX;
		end else if (sum_c < SUM_W'(SINE_MIN)) begin
			sat_c = SINE_MIN;
		end else begin
			sat_c = sum_c[SINE_W-1:0];
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s4) begin
				v_s4 <= in_valid;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	// stage 4: weighted difference
	always_ff @(posedge clk) begin
		if (en_s4 && in_valid) begin
			prod_s4 <= PROD_W'(diff) * PROD_W'($signed({1'b0, r}));
			a_s4    <= a;
		end
	end

	// stage 5: result word
	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			y_s5 <= sat_c;
		end
	end

	// interpolated value lies between two table samples, so no clamp fires
	a_no_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (sum_c <= SUM_W'(SINE_MAX) && sum_c >= SUM_W'(SINE_MIN)))
		else $error("interpolation left the sample range");

endmodule

// File: bench/tb_sine_table_interpolator.sv
// ---------------------------------------------------------------------------
// tb_sine_table_interpolator: testbench for the sine table interpolator
// Sends phase words on phase_ch and checks every sine word on sine_ch
// against a local predictor. The predictor builds its own 513-entry sine
// table with integer Taylor arithmetic and interpolates between neighbors.
// A directed set covers quadrant points, wrap, ignored integer bits and the
// table ends. Random words follow, with random gaps and stalls on both sides.
// ---------------------------------------------------------------------------
module tb_sine_table_interpolator;
	import sti_pkg::*;

	localparam int TABLE_SIZE  = 512;
	localparam int IDX_W       = $clog2(TABLE_SIZE);
	localparam int RANDOM_WORDS = 550;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 10;

	// Expected sine words in order, plus the sine table they come from
	class sine_scoreboard;
		logic signed [SINE_W-1:0] expected_sines[$];
		logic signed [SINE_W-1:0] sine_table[TABLE_SIZE+1];
		int errors;

		function new();
			errors = 0;
			for (int i = 0; i <= TABLE_SIZE; i++) begin
				sine_table[i] = table_sample(i);
			end
		endfunction

		// sin(a) for 0 <= a <= pi/2, angle and result in Q30
		function logic signed [63:0] taylor_sin_q30(logic [63:0] ang);
			logic [63:0]        term;
			logic signed [63:0] acc;
			term = ang;
			acc  = $signed(ang);
			for (int k = 1; k <= 10; k++) begin
				term = (term * ang) >> 30;
				term = (term * ang) >> 30;
				term = term / 64'((2 * k) * (2 * k + 1));
				if (k % 2 == 1) begin
					acc = acc - $signed(term);
				end else begin
					acc = acc + $signed(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			return acc;
		endfunction

		// entry i of one full period, folded to the first quadrant
		function logic signed [SINE_W-1:0] table_sample(int i);
			logic [63:0]        u;
			logic [63:0]        m;
			logic [63:0]        n;
			logic signed [63:0] v;
			bit                 neg;
			n = TABLE_SIZE;
			u = 4 * i;
			if (u <= n) begin
				m = u;
				neg = 0;
			end else if (u <= 2 * n) begin
				m = 2 * n - u;
				neg = 0;
			end else if (u <= 3 * n) begin
				m = u - 2 * n;
				neg = 1;
			end else begin
				m = 4 * n - u;
				neg = 1;
			end
			v = (taylor_sin_q30((m * HALF_PI_Q30) / n) + 64'sd16384) >>> 15;
			if (v > 64'sd32767) begin
				v = 64'sd32767;
			end
			return neg ? SINE_W'(-v) : SINE_W'(v);
		endfunction

		// interpolated sine of the phase fraction, floor rounding, clamped
		function logic signed [SINE_W-1:0] sine_of_phase(logic signed [PHASE_W-1:0] phase);
			logic [63:0] scaled;
			int          idx;
			longint      remain;
			longint      lo;
			longint      hi;
			longint      prod;
			longint      y;
			scaled = 64'(phase[FRAC_W-1:0]) * TABLE_SIZE;
			idx    = int'(scaled >> FRAC_W);
			remain = longint'(scaled & ((64'd1 << FRAC_W) - 1));
			if (idx >= TABLE_SIZE) begin
				idx = TABLE_SIZE - 1;
			end
			lo   = sine_table[idx];
			hi   = sine_table[idx+1];
			prod = (hi - lo) * remain;
			y    = lo + (prod >>> FRAC_W);
			if (y > longint'(SINE_MAX)) begin
				y = SINE_MAX;
			end
			if (y < longint'(SINE_MIN)) begin
				y = SINE_MIN;
			end
			return SINE_W'(y);
		endfunction

		function void note_phase(logic signed [PHASE_W-1:0] phase);
			expected_sines.push_back(sine_of_phase(phase));
		endfunction

		function void check_sine(logic signed [SINE_W-1:0] actual);
			logic signed [SINE_W-1:0] want;
			if (expected_sines.size() == 0) begin
				$error("sine_value: unexpected word %0d", actual);
				errors++;
			end else begin
				want = expected_sines.pop_front();
				if (actual !== want) begin
					$error("sine_value: expected %0d, actual %0d", want, actual);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_sines.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   no_gaps;
	int   idle_cycles;

	sti_phase_if phase_ch ();
	sti_sine_if  sine_ch ();

	sine_scoreboard sb = new();

	sine_table_interpolator #(.TABLE_SIZE(TABLE_SIZE)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.phase_ch (phase_ch),
		.sine_ch  (sine_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// send one phase word after a random gap
	task automatic send_phase(input logic signed [PHASE_W-1:0] phase);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			phase_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		phase_ch.valid <= 1'b1;
		phase_ch.phase <= phase;
		do @(posedge clk); while (!phase_ch.ready);
	endtask

	// hold off until every sine word in flight has come back; the clock steps first
	// so the monitor has logged the last accepted phase word
	task automatic drain_pipeline();
		phase_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// random phase, partly aimed at table boundaries and quadrant edges
	function automatic logic signed [PHASE_W-1:0] random_phase();
		logic [PHASE_W-1:0] p;
		int                 corner;
		p = $urandom();
		if ($urandom_range(0, 9) < 3) begin
			corner = $urandom_range(0, 3);
			case (corner)
				0: begin
					p[FRAC_W-IDX_W-1:0] = '0;
				end
				1: begin
					p[FRAC_W-IDX_W-1:0] = '1;
				end
				2: begin
					p[FRAC_W-1:FRAC_W-IDX_W] = IDX_W'($urandom_range(0, 3) * (TABLE_SIZE / 4));
				end
				default: begin
					p[FRAC_W-1:FRAC_W-IDX_W] =
						IDX_W'($urandom_range(1, 4) * (TABLE_SIZE / 4) - 1);
				end
			endcase
		end
		return p;
	endfunction

	// stimulus
	initial begin
		logic signed [PHASE_W-1:0] directed[$];
		directed = '{
			32'h0000_0000, 32'h0040_0000, 32'h0080_0000, 32'h00C0_0000,
			32'hFFC0_0000, 32'hFFFF_FFFF, 32'hFFFF_FE00, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h0540_0000, 32'h00FF_FFFF, 32'h00FF_8000,
			32'h003F_8000, 32'h0040_7FFF, 32'h003F_FFFF, 32'hAAAA_AAAA,
			32'h5555_5555, 32'h0000_0001, 32'h0000_7FFF, 32'h0000_8000,
			32'h1234_5678, 32'hFF80_0000, 32'h00BF_FFFF, 32'h0000_4000
		};
		no_gaps = 1'b0;
		arst_n <= 1'b0;
		phase_ch.valid <= 1'b0;
		phase_ch.phase <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_phase(directed[i]);
		end
		drain_pipeline();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// back-to-back stretches on both sides now and then
			if (n % 100 == 0) begin
				no_gaps = (n % 200 == 0);
			end
			if (n == RANDOM_WORDS / 2) begin
				drain_pipeline();
			end
			send_phase(random_phase());
		end
		drain_pipeline();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// result side: random stall before taking each sine word
	initial begin
		int stall;
		sine_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				sine_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			sine_ch.ready <= 1'b1;
			do @(posedge clk); while (!(sine_ch.valid && sine_ch.ready));
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (sine_ch.valid && sine_ch.ready) begin
				sb.check_sine(sine_ch.sine_value);
			end
			if (phase_ch.valid && phase_ch.ready) begin
				sb.note_phase(phase_ch.phase);
			end
			if ((sine_ch.valid && sine_ch.ready) || (phase_ch.valid && phase_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

endmodule
